[sv/reno_sender_window_control_core_macros.svh]
// Assertion macros for the Reno sender window control core.
// Included by reno_sender_window_control_core.sv; expects clk and rst_n in scope.
`ifndef RENO_SENDER_WINDOW_CONTROL_CORE_MACROS_SVH
`define RENO_SENDER_WINDOW_CONTROL_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RSWC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define RSWC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/rswc_pkg.sv]
// Shared types and constants for the Reno sender window control core.
// No dependencies; imported by reno_sender_window_control_core and its testbench.
`default_nettype none

package rswc_pkg;

    // Port widths (fixed by the item layout)
    localparam int FUNC_W     = 2;
    localparam int ACTION_W   = 3;
    localparam int ACK_W      = 32;
    localparam int SEQ_OUT_W  = 32;
    localparam int TH_W       = 16;
    localparam int WIN_W      = 8;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 72;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 16;

    // Reset values
    localparam logic [WIN_W-1:0] RESET_WINDOW   = 8'd16;
    localparam logic [TH_W-1:0]  RESET_SSTHRESH = 16'd32;
    localparam logic [TH_W-1:0]  TH_MAX         = 16'hFFFF;
    localparam logic [1:0]       DUP_LIMIT      = 2'd3;
    localparam int               FAST_RETX_INC  = 3;

    typedef enum logic [FUNC_W-1:0] {
        FN_ENQUEUE = 2'd0,
        FN_SEND    = 2'd1,
        FN_ACK     = 2'd2,
        FN_TIMEOUT = 2'd3
    } func_t;

    typedef enum logic [ACTION_W-1:0] {
        ACT_NONE      = 3'd0,
        ACT_SEND_NEW  = 3'd1,
        ACT_FAST_RETX = 3'd2,
        ACT_TO_RETX   = 3'd3,
        ACT_REFUSED   = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        PH_SLOW  = 2'd0,
        PH_AVOID = 2'd1,
        PH_RECOV = 2'd2
    } phase_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_WINDOW_SIZE = 1'd0,
        REG_INIT_SSTH   = 1'd1
    } cfg_reg_t;

endpackage

`default_nettype wire

[sv/reno_sender_window_control_core.sv]
// Reno sender window control core: sliding window plus Reno congestion control.
// Depends on rswc_pkg and reno_sender_window_control_core_macros.svh.
`default_nettype none

//  channel   | dir | handshake          | payload
//  ----------+-----+--------------------+-------------------------------------------
//  s_*       | in  | s_tvalid/s_tready  | tuser=func, tdata=ack_number,ack_valid
//  m_*       | out | m_tvalid/m_tready  | tuser=action, tdata=seq,cwnd,ssthresh,phase
//  cfg_*     | in  | cfg_we (no wait)   | cfg_addr register index, cfg_wdata value
//
// One item per cycle sustained while m_tready is high; input register, then result register.
// The single state update between those registers (compares and saturating adds on
// the window and cwnd) sets the rate.
// rst_n clears control and window state; cwnd=1, ssthresh=RESET_SSTHRESH, slow start.
// A stalled result holds in the result register while the input register still
// accepts; the input stalls only when both registers are full.

`include "reno_sender_window_control_core_macros.svh"

module reno_sender_window_control_core
    import rswc_pkg::*;
#(
    parameter int SEQ_BITS  = 32,
    parameter int CWND_BITS = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // input items
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // [31:0] ack_number, [32] ack_valid
    input  wire logic [FUNC_W-1:0]     s_tuser,   // [1:0] func
    // result items
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,   // [31:0] seq_number, [47:32] cwnd_now,
                                                  // [63:48] ssthresh_now, [65:64] phase_now
    output logic [ACTION_W-1:0]        m_tuser,   // [2:0] action
    // configuration writes
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    // cwnd is kept at least 16 bits wide: recovery may load ssthresh into it
    localparam int CWR = (CWND_BITS > TH_W) ? CWND_BITS : TH_W;
    localparam int MW  = (SEQ_BITS > CWR) ? SEQ_BITS : CWR;
    localparam int AW  = MW + 2;
    localparam logic [CWR-1:0] CWND_MAX = CWR'({CWND_BITS{1'b1}});
    localparam logic [CWR-1:0] CWND_ONE = CWR'(1);
    localparam logic [SEQ_BITS-1:0] SEQ_ONE = SEQ_BITS'(1);

    function automatic logic [CWR-1:0] cwnd_sat_add(input logic [CWR-1:0] c,
                                                    input logic [AW-1:0]  n);
        logic [AW-1:0] s;
        s = AW'(c) + n;
        if (s >= AW'(CWND_MAX))
            return CWND_MAX;
        return CWR'(s);
    endfunction

    function automatic logic [TH_W-1:0] half_thresh(input logic [CWR-1:0] c);
        logic [CWR-1:0] h;
        h = c >> 1;
        if (h > CWR'(TH_MAX))
            return TH_MAX;
        return TH_W'(h);
    endfunction

    // configuration
    logic [WIN_W-1:0]    window_size_reg;

    // input register
    logic                in_valid_reg;
    func_t               in_func_reg;
    logic [ACK_W-1:0]    in_ack_reg;
    logic                in_ack_valid_reg;

    // window and congestion state
    logic [SEQ_BITS-1:0] window_base_reg,  window_base_next;
    logic [SEQ_BITS-1:0] next_send_reg,    next_send_next;
    logic [SEQ_BITS-1:0] next_enqueue_reg, next_enqueue_next;
    logic [CWR-1:0]      cong_window_reg,  cong_window_next;
    logic [TH_W-1:0]     slow_thresh_reg,  slow_thresh_next;
    phase_t              phase_reg,        phase_next;
    logic [TH_W-1:0]     avoid_count_reg,  avoid_count_next;
    logic [1:0]          dup_acks_reg,     dup_acks_next;

    // result register
    logic                out_valid_reg;
    action_t             out_action_reg;
    logic [SEQ_OUT_W-1:0] out_seq_reg;
    logic [TH_W-1:0]     out_cwnd_reg;
    logic [TH_W-1:0]     out_ssth_reg;
    phase_t              out_phase_reg;

    // event evaluation
    logic                fire;
    action_t             act_c;
    logic [SEQ_BITS-1:0] seq_c;
    logic [SEQ_BITS-1:0] inflight;
    logic [SEQ_BITS-1:0] enq_dist;
    logic [SEQ_BITS-1:0] ack_seq;
    logic [SEQ_BITS-1:0] ack_off;
    logic [AW-1:0]       ack_num;
    logic [1:0]          dup_inc;

    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    always_comb
    begin
        window_base_next  = window_base_reg;
        next_send_next    = next_send_reg;
        next_enqueue_next = next_enqueue_reg;
        cong_window_next  = cong_window_reg;
        slow_thresh_next  = slow_thresh_reg;
        phase_next        = phase_reg;
        avoid_count_next  = avoid_count_reg;
        dup_acks_next     = dup_acks_reg;
        act_c             = ACT_NONE;
        seq_c             = '0;

        // modular distances from the window base
        inflight = next_send_reg - window_base_reg;
        enq_dist = next_enqueue_reg - window_base_reg;
        ack_seq  = SEQ_BITS'(in_ack_reg);
        ack_off  = ack_seq - window_base_reg;
        ack_num  = AW'(ack_off) + AW'(1);
        dup_inc  = dup_acks_reg + 2'd1;

        unique case (in_func_reg)
            FN_ENQUEUE:
            begin
                // buffer holds 2N segments
                if (AW'(enq_dist) >= (AW'(window_size_reg) << 1))
                    act_c = ACT_REFUSED;
                else
                    next_enqueue_next = next_enqueue_reg + SEQ_ONE;
            end
            FN_SEND:
            begin
                if (AW'(inflight) < AW'(window_size_reg) &&
                    inflight < enq_dist &&
                    AW'(inflight) < AW'(cong_window_reg))
                begin
                    act_c          = ACT_SEND_NEW;
                    seq_c          = next_send_reg;
                    next_send_next = next_send_reg + SEQ_ONE;
                end
            end
            FN_ACK:
            begin
                if (in_ack_valid_reg)
                begin
                    if (ack_off < inflight)
                    begin
                        // new cumulative ACK
                        dup_acks_next = '0;
                        priority if (phase_reg == PH_SLOW)
                        begin
                            cong_window_next = cwnd_sat_add(cong_window_reg, ack_num);
                            if (cong_window_next >= CWR'(slow_thresh_reg))
                            begin
                                avoid_count_next = '0;
                                phase_next       = PH_AVOID;
                            end
                        end
                        else if (phase_reg == PH_RECOV)
                        begin
                            cong_window_next = (slow_thresh_reg != '0) ?
                                               CWR'(slow_thresh_reg) : CWND_ONE;
                            phase_next       = PH_AVOID;
                        end
                        else
                        begin
                            if (ack_num >= AW'(TH_MAX - avoid_count_reg))
                                avoid_count_next = TH_MAX;
                            else
                                avoid_count_next = avoid_count_reg + TH_W'(ack_num);
                            if (CWR'(avoid_count_next) >= cong_window_reg)
                            begin
                                cong_window_next = cwnd_sat_add(cong_window_reg, AW'(1));
                                avoid_count_next = '0;
                            end
                        end
                        window_base_next = ack_seq + SEQ_ONE;
                    end
                    else
                    begin
                        // duplicate ACK; third one triggers fast retransmit
                        dup_acks_next = dup_inc;
                        if (dup_inc == DUP_LIMIT)
                        begin
                            act_c         = ACT_FAST_RETX;
                            seq_c         = window_base_reg;
                            dup_acks_next = '0;
                            if (phase_reg != PH_RECOV)
                            begin
                                phase_next       = PH_RECOV;
                                slow_thresh_next = half_thresh(cong_window_reg);
                                cong_window_next = cwnd_sat_add(CWR'(slow_thresh_next),
                                                                AW'(FAST_RETX_INC));
                            end
                        end
                        if (phase_next == PH_RECOV)
                            cong_window_next = cwnd_sat_add(cong_window_next, AW'(1));
                    end
                end
            end
            FN_TIMEOUT:
            begin
                if (inflight != '0)
                begin
                    dup_acks_next    = '0;
                    slow_thresh_next = half_thresh(cong_window_reg);
                    cong_window_next = CWND_ONE;
                    phase_next       = PH_SLOW;
                    act_c            = ACT_TO_RETX;
                    seq_c            = window_base_reg;
                end
            end
            default:
            begin
                act_c = ACT_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg  <= RESET_WINDOW;
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            window_base_reg  <= SEQ_ONE;
            next_send_reg    <= SEQ_ONE;
            next_enqueue_reg <= SEQ_ONE;
            cong_window_reg  <= CWND_ONE;
            slow_thresh_reg  <= RESET_SSTHRESH;
            phase_reg        <= PH_SLOW;
            avoid_count_reg  <= '0;
            dup_acks_reg     <= '0;
        end
        else
        begin
            // input register
            if (s_tready)
                in_valid_reg <= s_tvalid;

            // result register
            if (fire)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            if (fire)
            begin
                window_base_reg  <= window_base_next;
                next_send_reg    <= next_send_next;
                next_enqueue_reg <= next_enqueue_next;
                cong_window_reg  <= cong_window_next;
                phase_reg        <= phase_next;
                avoid_count_reg  <= avoid_count_next;
                dup_acks_reg     <= dup_acks_next;
            end

            // config writes must be made only while idle, which the block does not enforce; ssthresh reloads on write
            priority if (cfg_we && cfg_addr == REG_INIT_SSTH)
                slow_thresh_reg <= cfg_wdata;
            else if (fire)
                slow_thresh_reg <= slow_thresh_next;

            if (cfg_we && cfg_addr == REG_WINDOW_SIZE)
                window_size_reg <= cfg_wdata[WIN_W-1:0];
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_func_reg      <= func_t'(s_tuser);
            in_ack_reg       <= s_tdata[ACK_W-1:0];
            in_ack_valid_reg <= s_tdata[ACK_W];
        end
        if (fire)
        begin
            out_action_reg <= act_c;
            out_seq_reg    <= SEQ_OUT_W'(seq_c);
            out_cwnd_reg   <= (cong_window_next > CWR'(TH_MAX)) ?
                              TH_MAX : TH_W'(cong_window_next);
            out_ssth_reg   <= slow_thresh_next;
            out_phase_reg  <= phase_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_action_reg;
    assign m_tdata  = {6'b0, out_phase_reg, out_ssth_reg, out_cwnd_reg, out_seq_reg};

    // checks
    `RSWC_ASSERT_NOW(a_dup_below_limit, 1'b1, dup_acks_reg != DUP_LIMIT,
        "duplicate ACK count reached limit without clearing")
    `RSWC_ASSERT_NEXT(a_result_loaded, fire, out_valid_reg,
        "processed item did not load result register")
    `RSWC_ASSERT_NEXT(a_send_advances, fire && act_c == ACT_SEND_NEW,
        next_send_reg == $past(next_send_reg) + SEQ_ONE,
        "send did not advance next sequence")
    `RSWC_ASSERT_NEXT(a_timeout_resets_cwnd, fire && act_c == ACT_TO_RETX,
        cong_window_reg == CWND_ONE && phase_reg == PH_SLOW,
        "timeout did not return to slow start with cwnd of one")

endmodule

`default_nettype wire

[test/reno_sender_window_control_core_tb.sv]
// Self-checking bench for reno_sender_window_control_core: stream events in, compare results.
// Carries its own window/congestion predictor; depends on rswc_pkg and the core RTL only.
`default_nettype none

module reno_sender_window_control_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rswc_pkg::*;

    localparam int STALL_LIMIT = 2000;   // cycles with no handshake on either side
    localparam int HOLD_CYCLES = 80;     // long result-side hold, fills the core
    localparam int FLOOD_DUPS  = 12;     // duplicates: several fast retransmits in recovery

    // one result item, decoded
    typedef struct packed {
        action_t     action;
        logic [31:0] seq;
        logic [15:0] cwnd;
        logic [15:0] ssth;
        phase_t      phase;
    } window_result_t;

    // one row of the opening sequence; typed rows carry a hand-written result
    typedef struct packed {
        func_t          f;
        logic [31:0]    ackn;
        logic           av;
        logic           typed;
        window_result_t want;
    } probe_row_t;

    localparam window_result_t AT_RESET  = '{ACT_NONE, 32'd0, 16'd1, 16'd32, PH_SLOW};
    // third duplicate with nothing in flight: ssthresh 1/2 = 0, cwnd 0+3, then +1
    localparam window_result_t FIRST_FRX = '{ACT_FAST_RETX, 32'd1, 16'd4, 16'd0, PH_RECOV};
    localparam window_result_t NO_WANT   = '{ACT_NONE, 32'd0, 16'd0, 16'd0, PH_SLOW};

    localparam probe_row_t OPENING [24] = '{
        '{FN_TIMEOUT, 32'h0000_0000, 1'b0, 1'b1, AT_RESET},   // timeout, nothing out
        '{FN_SEND,    32'hFFFF_FFFF, 1'b1, 1'b1, AT_RESET},   // send, empty buffer
        '{FN_ACK,     32'h0000_0000, 1'b1, 1'b1, AT_RESET},   // first duplicate
        '{FN_ACK,     32'hFFFF_FFFF, 1'b0, 1'b1, AT_RESET},   // bad ack ignored
        '{FN_ACK,     32'hFFFF_FFFF, 1'b1, 1'b1, AT_RESET},   // second duplicate
        '{FN_ACK,     32'h0000_0001, 1'b1, 1'b1, FIRST_FRX},  // fast retx, nothing out
        '{FN_ENQUEUE, 32'h0000_0000, 1'b0, 1'b0, NO_WANT},
        '{FN_ENQUEUE, 32'hFFFF_FFFF, 1'b1, 1'b0, NO_WANT},
        '{FN_ENQUEUE, 32'h5555_AAAA, 1'b0, 1'b0, NO_WANT},
        '{FN_SEND,    32'h0000_0000, 1'b0, 1'b0, NO_WANT},
        '{FN_SEND,    32'h0000_0000, 1'b0, 1'b0, NO_WANT},
        '{FN_SEND,    32'h0000_0000, 1'b0, 1'b0, NO_WANT},
        '{FN_SEND,    32'h0000_0000, 1'b0, 1'b0, NO_WANT},    // buffer drained
        '{FN_ACK,     32'h0000_0001, 1'b1, 1'b0, NO_WANT},    // new ack leaves recovery
        '{FN_ACK,     32'h0000_0001, 1'b1, 1'b0, NO_WANT},    // below base: duplicate
        '{FN_ACK,     32'h0000_0004, 1'b1, 1'b0, NO_WANT},    // equals next send: duplicate
        '{FN_ACK,     32'h8000_0000, 1'b1, 1'b0, NO_WANT},    // third: fast retx in avoidance
        '{FN_ACK,     32'h0000_0003, 1'b1, 1'b0, NO_WANT},    // acks two at once
        '{FN_TIMEOUT, 32'h0000_0000, 1'b0, 1'b0, NO_WANT},
        '{FN_ENQUEUE, 32'h0000_0000, 1'b0, 1'b0, NO_WANT},
        '{FN_SEND,    32'h0000_0000, 1'b0, 1'b0, NO_WANT},
        '{FN_TIMEOUT, 32'h0000_0000, 1'b0, 1'b0, NO_WANT},    // timeout retransmit
        '{FN_ACK,     32'h0000_0004, 1'b1, 1'b0, NO_WANT},
        '{FN_ACK,     32'h0000_0000, 1'b0, 1'b0, NO_WANT}
    };

    // ---------------------------------------------------------------- DUT
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [FUNC_W-1:0]     s_tuser   = FN_ENQUEUE;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [ACTION_W-1:0]   m_tuser;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = REG_WINDOW_SIZE;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    reno_sender_window_control_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #1 clk = ~clk;

    // ---------------------------------------------------------- predictor
    // Window and congestion state as the core should hold it; starts at reset values.
    logic [7:0]  p_window    = RESET_WINDOW;
    logic [31:0] p_base      = 32'd1;
    logic [31:0] p_next_send = 32'd1;
    logic [31:0] p_next_enq  = 32'd1;
    logic [15:0] p_cwnd      = 16'd1;
    logic [15:0] p_ssth      = RESET_SSTHRESH;
    phase_t      p_phase     = PH_SLOW;
    logic [15:0] p_avoid     = 16'd0;
    logic [1:0]  p_dups      = 2'd0;

    window_result_t pending_results [$];   // oldest first
    int unsigned    mismatches   = 0;
    bit             calm         = 1'b0;   // no idling on either side while set
    int unsigned    hold_asked   = 0;
    int unsigned    hold_given   = 0;
    int unsigned    hold_left    = 0;
    int unsigned    quiet_cycles = 0;

    // cwnd grows saturating at its 16-bit ceiling
    function automatic logic [15:0] widen_cwnd(logic [15:0] c, longint unsigned n);
        longint unsigned sum;
        sum = n + c;
        return (sum >= 64'hFFFF) ? 16'hFFFF : sum[15:0];
    endfunction

    // Applies one event to the predicted state and returns the result it should give.
    function automatic window_result_t advance_window(func_t f, logic [31:0] ackn, logic av);
        window_result_t  r;
        logic [31:0]     inflight;
        logic [31:0]     queued;
        logic [31:0]     off;
        logic [15:0]     room;
        longint unsigned num;
        inflight = p_next_send - p_base;
        queued   = p_next_enq - p_base;
        r.action = ACT_NONE;
        r.seq    = '0;
        case (f)
            FN_ENQUEUE:
            begin
                // buffer holds two windows; zero window refuses everything
                if (queued >= {23'd0, p_window, 1'b0})
                    r.action = ACT_REFUSED;
                else
                    p_next_enq = p_next_enq + 32'd1;
            end
            FN_SEND:
            begin
                if (inflight < {24'd0, p_window} && inflight < queued &&
                    inflight < {16'd0, p_cwnd})
                begin
                    r.action    = ACT_SEND_NEW;
                    r.seq       = p_next_send;
                    p_next_send = p_next_send + 32'd1;
                end
            end
            FN_ACK:
            begin
                if (av)
                begin
                    off = ackn - p_base;
                    if (off < inflight)
                    begin
                        // cumulative ack covering off+1 segments
                        num    = longint'(off) + 1;
                        p_dups = 2'd0;
                        case (p_phase)
                            PH_SLOW:
                            begin
                                p_cwnd = widen_cwnd(p_cwnd, num);
                                if (p_cwnd >= p_ssth)
                                begin
                                    p_avoid = 16'd0;
                                    p_phase = PH_AVOID;
                                end
                            end
                            PH_RECOV:
                            begin
                                p_cwnd  = (p_ssth != 16'd0) ? p_ssth : 16'd1;
                                p_phase = PH_AVOID;
                            end
                            default:
                            begin
                                room = TH_MAX - p_avoid;
                                if (num >= room)
                                    p_avoid = TH_MAX;
                                else
                                    p_avoid = p_avoid + num[15:0];
                                if (p_avoid >= p_cwnd)
                                begin
                                    p_cwnd  = widen_cwnd(p_cwnd, 1);
                                    p_avoid = 16'd0;
                                end
                            end
                        endcase
                        p_base = ackn + 32'd1;
                    end
                    else
                    begin
                        p_dups = p_dups + 2'd1;
                        if (p_dups >= DUP_LIMIT)
                        begin
                            r.action = ACT_FAST_RETX;
                            r.seq    = p_base;
                            p_dups   = 2'd0;
                            if (p_phase != PH_RECOV)
                            begin
                                p_phase = PH_RECOV;
                                p_ssth  = p_cwnd >> 1;
                                p_cwnd  = widen_cwnd(p_ssth, FAST_RETX_INC);
                            end
                        end
                        if (p_phase == PH_RECOV)
                            p_cwnd = widen_cwnd(p_cwnd, 1);
                    end
                end
            end
            default:
            begin
                if (inflight != 32'd0)
                begin
                    p_dups   = 2'd0;
                    p_ssth   = p_cwnd >> 1;
                    p_cwnd   = 16'd1;
                    p_phase  = PH_SLOW;
                    r.action = ACT_TO_RETX;
                    r.seq    = p_base;
                end
            end
        endcase
        r.cwnd  = p_cwnd;
        r.ssth  = p_ssth;
        r.phase = p_phase;
        return r;
    endfunction

    // ------------------------------------------------------------- sender
    // Offers one event item; returns at the edge that accepted it with s_tvalid still
    // high, so a follow-on item keeps the valid asserted without a gap unless random idling is on.
    task automatic offer_event(input func_t f, input logic [31:0] ackn, input logic av,
                               input logic typed, input window_result_t want);
        window_result_t predicted;
        while (!calm && $urandom_range(99) < 17)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= {{(S_TDATA_W-33){1'b0}}, av, ackn};
        do
            @(posedge clk);
        while (!s_tready);
        predicted = advance_window(f, ackn, av);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // Mostly well-formed traffic: acks aimed at the outstanding range or just below
    // it, with some bad acks and stray ack numbers mixed in.
    task automatic offer_random();
        func_t       f;
        logic [31:0] ackn;
        logic        av;
        logic [31:0] inflight;
        int unsigned roll;
        inflight = p_next_send - p_base;
        ackn     = $urandom();
        av       = ($urandom_range(99) >= 8);
        roll     = $urandom_range(99);
        if (roll < 30)
            f = FN_ENQUEUE;
        else if (roll < 60)
            f = FN_SEND;
        else if (roll < 93)
        begin
            f    = FN_ACK;
            roll = $urandom_range(99);
            if (roll < 45)
                ackn = p_base + $urandom_range(inflight) - 32'd1;
            else if (roll < 75)
                ackn = p_base - 32'd1;
        end
        else
            f = FN_TIMEOUT;
        offer_event(f, ackn, av, 1'b0, NO_WANT);
    endtask

    task automatic random_burst(input int unsigned n);
        repeat (n)
            offer_random();
    endtask

    // Stop offering, wait for every result, then let the two-stage pipe go quiet.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_addr  <= r;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (r == REG_WINDOW_SIZE)
            p_window = v[7:0];
        else
        begin
            // writing the threshold register also reloads the live ssthresh
            p_ssth = v;
        end
        @(posedge clk);
    endtask

    task automatic retune(input logic [7:0] win, input logic [15:0] ssth);
        settle();
        write_reg(REG_WINDOW_SIZE, {8'd0, win});
        write_reg(REG_INIT_SSTH, ssth);
    endtask

    // A run of duplicate acks enters fast recovery and grows cwnd one step per
    // duplicate; then a threshold of 65535 and a new ack load that ceiling into
    // avoidance; a timeout follows. Idling then stays off until the caller clears it.
    task automatic flood_duplicates();
        calm = 1'b1;
        repeat (4) offer_event(FN_ENQUEUE, $urandom(), 1'b1, 1'b0, NO_WANT);
        repeat (4) offer_event(FN_SEND, $urandom(), 1'b0, 1'b0, NO_WANT);
        repeat (FLOOD_DUPS)
            offer_event(FN_ACK, p_next_send + $urandom_range(32'h7FFF_FFFF), 1'b1,
                        1'b0, NO_WANT);
        settle();
        write_reg(REG_INIT_SSTH, TH_MAX);
        offer_event(FN_ACK, p_base, 1'b1, 1'b0, NO_WANT);
        offer_event(FN_TIMEOUT, 32'd0, 1'b0, 1'b0, NO_WANT);
    endtask

    // ----------------------------------------------------------- receiver
    // Random ready; a requested hold keeps ready low long enough to back up the input.
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else if (hold_asked != hold_given)
        begin
            hold_given <= hold_given + 1;
            hold_left  <= HOLD_CYCLES;
            m_tready   <= 1'b0;
        end
        else
            m_tready <= calm || ($urandom_range(99) >= 17);
    end

    task automatic compare_field(input string name, input longint unsigned want,
                                 input longint unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Every accepted result item is matched against the oldest prediction.
    always @(posedge clk)
    begin
        window_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result item with none expected: action %0d seq %0d",
                       m_tuser, m_tdata[31:0]);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                compare_field("action", want.action, m_tuser);
                compare_field("seq_number", want.seq, m_tdata[31:0]);
                compare_field("cwnd_now", want.cwnd, m_tdata[47:32]);
                compare_field("ssthresh_now", want.ssth, m_tdata[63:48]);
                compare_field("phase_now", want.phase, m_tdata[65:64]);
            end
        end
    end

    // Watchdog: too long without a handshake on either side ends the run.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // --------------------------------------------------------- main flow
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // opening sequence at reset settings
        for (int i = 0; i < 24; i++)
            offer_event(OPENING[i].f, OPENING[i].ackn, OPENING[i].av,
                        OPENING[i].typed, OPENING[i].want);

        // window and threshold of one: buffer of two, refusals common
        retune(8'd1, 16'd1);
        random_burst(70);

        // widest window, top threshold; receiver holds off to fill the core
        retune(8'd255, 16'hFFFF);
        hold_asked = hold_asked + 1;
        random_burst(100);

        // zero window: every enqueue refused and no send goes out, acks still drain
        retune(8'd0, 16'd8);
        random_burst(15);

        retune(8'd2, 16'd3);
        random_burst(70);

        retune(RESET_WINDOW, RESET_SSTHRESH);
        flood_duplicates();

        // still no idling on either side through this burst
        retune(8'($urandom_range(1, 255)), 16'($urandom_range(1, 65535)));
        random_burst(90);
        calm = 1'b0;

        retune(8'd4, 16'($urandom_range(1, 12)));
        random_burst(70);

        settle();
        if (mismatches == 0 && pending_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
